// ----- sv/pgd_pkg.sv -----
// Shared types and constants of the pointer gesture detector.
`default_nettype none
package pgd_pkg;

	localparam int NUM_BUTTONS_DEF = 4;
	localparam int COORD_BITS_DEF  = 16;

	// Above this magnitude a coordinate difference is taken as saturated.
	localparam int SQ_LIMIT = 46340;

	localparam logic [15:0] RESET_WINDOW_MS = 16'd400;
	localparam logic [7:0]  RESET_DEADZONE  = 8'd5;

	localparam int IN_W   = 72;
	localparam int USER_W = 3;
	localparam int OUT_W  = 104;

	typedef enum logic [2:0] {
		CMD_BEGIN_FRAME = 3'd0,
		CMD_END_FRAME   = 3'd1,
		CMD_BUTTON_DOWN = 3'd2,
		CMD_BUTTON_UP   = 3'd3,
		CMD_MOVE        = 3'd4
	} cmd_t;

	typedef enum logic {
		REG_WINDOW   = 1'b0,
		REG_DEADZONE = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		SRC_DZ = 2'd0,
		SRC_X  = 2'd1,
		SRC_Y  = 2'd2
	} diff_src_t;

	typedef enum logic [1:0] {
		MAC_HOLD = 2'd0,
		MAC_SET  = 2'd1,
		MAC_ADD  = 2'd2
	} mac_op_t;

	typedef struct packed {
		logic      ld;
		diff_src_t src;
		mac_op_t   mac;
	} dist_op_t;

endpackage
`default_nettype wire

// ----- sv/pointer_gesture_detector_core.sv -----
// Pointer gesture detector: click, double click and drag per button.
//
// Input stream: s_tvalid/s_tready/s_tdata/s_tuser carry one pointer event
// (command in tuser; time, button and position in tdata). Each event gives
// exactly one result item on m_tvalid/m_tready/m_tdata holding the frame's
// one-shot masks, held and latched dragging masks, latched delta and cursor.
// Configuration: cfg_we/cfg_idx/cfg_wdata write the double click window
// (index 0) and the deadzone radius (index 1), taken whenever cfg_we is high.
// Frame, press and unknown events and releases without a click check pass
// S_IDLE, S_EXEC and S_OUT. A click check on release and a move also use
// the single distance unit: it squares the deadzone once, then per button
// checked (the released one, or every button on a move) it loads both
// differences, squares them into the accumulator and compares.
// One event is in work at a time; s_tready is low until its result sits in
// the output register. A stalled receiver holds the result there; the next
// event is still accepted, and its result waits until the slot frees.
// Reset clears the tracked state but the origin and click positions and loads
// the window (400 ms) and the deadzone (5 pixels); no clearing pass is needed.
`default_nettype none
module pointer_gesture_detector_core import pgd_pkg::*; #(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	// time_ms[31:0], button[34:32], x_pos[50:35], y_pos[66:51], zero pad
	input  wire  [IN_W-1:0]   s_tdata,
	// command[2:0]
	input  wire  [USER_W-1:0] s_tuser,
	output logic              m_tvalid,
	input  wire               m_tready,
	// click[3:0], double_click[7:4], drag_begin[11:8], drag_done[15:12],
	// pressed[19:16], released[23:20], held[27:24], dragging[31:28],
	// delta_x[48:32], delta_y[65:49], cursor_x[81:66], cursor_y[97:82], pad
	output logic [OUT_W-1:0]  m_tdata,
	input  wire               cfg_we,
	input  wire  [0:0]        cfg_idx,
	input  wire  [15:0]       cfg_wdata
);

	localparam int NB = NUM_BUTTONS;
	localparam int CB = COORD_BITS;
	localparam int IW = (NB > 1) ? $clog2(NB) : 1;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_DZ_LD, S_DZ_SQ, S_DZ_CAP,
		S_DX, S_DY, S_SUM, S_CMP, S_OUT
	} state_t;

	state_t state_q;

	// event fields
	logic [31:0]         in_time;
	logic [2:0]          in_button;
	logic signed [15:0]  in_x;
	logic signed [15:0]  in_y;
	logic signed [CB-1:0] x_c;
	logic signed [CB-1:0] y_c;

	cmd_t                cmd_q;
	logic                btn_ok_q;
	logic [IW-1:0]       idx_q;
	logic [31:0]         time_q;
	logic signed [CB-1:0] x_q;
	logic signed [CB-1:0] y_q;

	// tracked state
	logic [NB-1:0]       held_q, drag_q;
	logic [NB-1:0]       os_click_q, os_dbl_q, os_dstart_q, os_dend_q;
	logic [NB-1:0]       os_press_q, os_rel_q, lat_drag_q;
	logic [31:0]         click_t_q [NB];
	logic signed [CB-1:0] click_x_q [NB];
	logic signed [CB-1:0] click_y_q [NB];
	logic signed [CB-1:0] org_x_q [NB];
	logic signed [CB-1:0] org_y_q [NB];
	logic [31:0]         frame_time_q;
	logic signed [CB-1:0] cur_x_q, cur_y_q, start_x_q, start_y_q;
	logic signed [16:0]  lat_dx_q, lat_dy_q;
	logic [15:0]         window_q;
	logic [7:0]          dz_q;
	logic [15:0]         dzsq_q;
	logic                m_valid_q;
	logic [OUT_W-1:0]    m_data_q;

	// datapath glue
	logic [NB-1:0]       bsel;
	logic signed [CB-1:0] ref_x, ref_y;
	logic signed [CB:0]  dx_frame, dy_frame;
	dist_op_t            op;
	logic [32:0]         acc;
	logic                sat;
	logic                far;
	logic                dbl;
	logic                org_we;
	logic                click_we;
	logic                accept;
	logic [OUT_W-1:0]    out_pack;

	assign in_time   = s_tdata[31:0];
	assign in_button = s_tdata[34:32];
	assign in_x      = s_tdata[50:35];
	assign in_y      = s_tdata[66:51];
	assign x_c       = CB'(in_x);
	assign y_c       = CB'(in_y);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign bsel  = NB'(1) << idx_q;
	assign ref_x = (cmd_q == CMD_BUTTON_UP) ? click_x_q[idx_q] : org_x_q[idx_q];
	assign ref_y = (cmd_q == CMD_BUTTON_UP) ? click_y_q[idx_q] : org_y_q[idx_q];

	assign dx_frame = (CB+1)'(cur_x_q) - (CB+1)'(start_x_q);
	assign dy_frame = (CB+1)'(cur_y_q) - (CB+1)'(start_y_q);

	// saturated distances always lie beyond the deadzone
	assign far = sat || (acc > 33'(dzsq_q));
	assign dbl = (click_t_q[idx_q] != 32'd0)
		&& ((frame_time_q - click_t_q[idx_q]) < 32'(window_q))
		&& !far;

	assign org_we   = (state_q == S_EXEC) && (cmd_q == CMD_BUTTON_DOWN) && btn_ok_q;
	assign click_we = (state_q == S_CMP) && (cmd_q == CMD_BUTTON_UP);

	always_comb begin
		op = '{ld: 1'b0, src: SRC_DZ, mac: MAC_HOLD};
		case (state_q)
			S_DZ_LD:  op = '{ld: 1'b1, src: SRC_DZ, mac: MAC_HOLD};
			S_DZ_SQ:  op = '{ld: 1'b0, src: SRC_DZ, mac: MAC_SET};
			S_DZ_CAP: op = '{ld: 1'b1, src: SRC_X,  mac: MAC_HOLD};
			S_DX:     op = '{ld: 1'b1, src: SRC_X,  mac: MAC_HOLD};
			S_DY:     op = '{ld: 1'b1, src: SRC_Y,  mac: MAC_SET};
			S_SUM:    op = '{ld: 1'b0, src: SRC_Y,  mac: MAC_ADD};
			default:  ;
		endcase
	end

	pgd_dist_unit #(
		.COORD_BITS(CB)
	) u_dist (
		.clk (clk),
		.op  (op),
		.ax  (cur_x_q),
		.bx  (ref_x),
		.ay  (cur_y_q),
		.by  (ref_y),
		.dz  (dz_q),
		.acc (acc),
		.sat (sat)
	);

	assign out_pack = {
		6'd0,
		16'(cur_y_q), 16'(cur_x_q),
		lat_dy_q, lat_dx_q,
		4'(lat_drag_q), 4'(held_q), 4'(os_rel_q), 4'(os_press_q),
		4'(os_dend_q), 4'(os_dstart_q), 4'(os_dbl_q), 4'(os_click_q)
	};

	// positions of press origins and last clicks; not reset, used only once written
	always_ff @(posedge clk) begin
		if (org_we) begin
			org_x_q[idx_q] <= x_q;
			org_y_q[idx_q] <= y_q;
		end
		if (click_we) begin
			click_x_q[idx_q] <= cur_x_q;
			click_y_q[idx_q] <= cur_y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= CMD_BEGIN_FRAME;
			btn_ok_q     <= 1'b0;
			idx_q        <= '0;
			time_q       <= '0;
			x_q          <= '0;
			y_q          <= '0;
			held_q       <= '0;
			drag_q       <= '0;
			os_click_q   <= '0;
			os_dbl_q     <= '0;
			os_dstart_q  <= '0;
			os_dend_q    <= '0;
			os_press_q   <= '0;
			os_rel_q     <= '0;
			lat_drag_q   <= '0;
			for (int i = 0; i < NB; i++) click_t_q[i] <= '0;
			frame_time_q <= '0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			start_x_q    <= '0;
			start_y_q    <= '0;
			lat_dx_q     <= '0;
			lat_dy_q     <= '0;
			window_q     <= RESET_WINDOW_MS;
			dz_q         <= RESET_DEADZONE;
			dzsq_q       <= '0;
			m_valid_q    <= 1'b0;
			m_data_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_WINDOW:   window_q <= cfg_wdata;
					REG_DEADZONE: dz_q     <= cfg_wdata[7:0];
					default:      ;
				endcase
			end

			// S_OUT reloads the slot itself
			if (m_valid_q && m_tready && (state_q != S_OUT)) m_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= cmd_t'(s_tuser[2:0]);
						btn_ok_q <= 4'(in_button) < 4'(NB);
						idx_q    <= (cmd_t'(s_tuser[2:0]) == CMD_MOVE) ? '0 : IW'(in_button);
						time_q   <= in_time;
						x_q      <= x_c;
						y_q      <= y_c;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (cmd_q)
						CMD_BEGIN_FRAME: begin
							start_x_q    <= cur_x_q;
							start_y_q    <= cur_y_q;
							frame_time_q <= time_q;
							os_click_q   <= '0;
							os_dbl_q     <= '0;
							os_dstart_q  <= '0;
							os_dend_q    <= '0;
							os_press_q   <= '0;
							os_rel_q     <= '0;
							state_q      <= S_OUT;
						end
						CMD_END_FRAME: begin
							lat_dx_q   <= 17'(dx_frame);
							lat_dy_q   <= 17'(dy_frame);
							lat_drag_q <= held_q & drag_q;
							state_q    <= S_OUT;
						end
						CMD_BUTTON_DOWN: begin
							if (btn_ok_q) begin
								cur_x_q    <= x_q;
								cur_y_q    <= y_q;
								os_press_q <= os_press_q | bsel;
								held_q     <= held_q | bsel;
								drag_q     <= drag_q & ~bsel;
							end
							state_q <= S_OUT;
						end
						CMD_BUTTON_UP: begin
							if (btn_ok_q) begin
								cur_x_q  <= x_q;
								cur_y_q  <= y_q;
								os_rel_q <= os_rel_q | bsel;
								if (drag_q[idx_q]) begin
									os_dend_q <= os_dend_q | bsel;
									held_q    <= held_q & ~bsel;
									drag_q    <= drag_q & ~bsel;
									state_q   <= S_OUT;
								end else if (held_q[idx_q]) begin
									state_q <= S_DZ_LD;
								end else begin
									state_q <= S_OUT;
								end
							end else begin
								state_q <= S_OUT;
							end
						end
						CMD_MOVE: begin
							cur_x_q <= x_q;
							cur_y_q <= y_q;
							state_q <= S_DZ_LD;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_DZ_LD:  state_q <= S_DZ_SQ;
				S_DZ_SQ:  state_q <= S_DZ_CAP;
				S_DZ_CAP: begin
					dzsq_q  <= acc[15:0];
					state_q <= S_DY;
				end
				S_DX:  state_q <= S_DY;
				S_DY:  state_q <= S_SUM;
				S_SUM: state_q <= S_CMP;
				S_CMP: begin
					if (cmd_q == CMD_BUTTON_UP) begin
						if (dbl) begin
							os_dbl_q   <= os_dbl_q | bsel;
							os_click_q <= os_click_q & ~bsel;
						end else begin
							os_click_q <= os_click_q | bsel;
							os_dbl_q   <= os_dbl_q & ~bsel;
						end
						click_t_q[idx_q] <= frame_time_q;
						held_q  <= held_q & ~bsel;
						drag_q  <= drag_q & ~bsel;
						state_q <= S_OUT;
					end else begin
						if (held_q[idx_q] && !drag_q[idx_q] && far) begin
							drag_q      <= drag_q | bsel;
							os_dstart_q <= os_dstart_q | bsel;
						end
						if (idx_q == IW'(NB - 1)) begin
							state_q <= S_OUT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_DX;
						end
					end
				end
				S_OUT: begin
					// wait for the output slot, then show the state after the item
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= out_pack;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
`default_nettype wire

// ----- sv/pgd_dist_unit.sv -----
// Shared distance unit: absolute difference stage, then square and accumulate.
`default_nettype none
module pgd_dist_unit import pgd_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire                          clk,
	input  wire dist_op_t                op,
	input  wire logic signed [COORD_BITS-1:0] ax,
	input  wire logic signed [COORD_BITS-1:0] bx,
	input  wire logic signed [COORD_BITS-1:0] ay,
	input  wire logic signed [COORD_BITS-1:0] by,
	input  wire logic [7:0]              dz,
	output logic [32:0]                  acc,
	output logic                         sat
);

	localparam int DW = COORD_BITS + 1;

	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic signed [DW-1:0] d;
	logic [DW-1:0]        mag;
	logic                 over;
	logic [15:0]          diff_d;
	logic                 over_d;
	logic [15:0]          diff_s1;
	logic                 sat_s1;
	logic [31:0]          sq;
	logic [32:0]          acc_q;
	logic                 sat_q;

	always_comb begin
		dx   = DW'(ax) - DW'(bx);
		dy   = DW'(ay) - DW'(by);
		d    = (op.src == SRC_Y) ? dy : dx;
		mag  = d[DW-1] ? DW'(-d) : DW'(d);
		over = 32'(mag) > 32'(SQ_LIMIT);
		case (op.src)
			SRC_DZ: begin
				diff_d = 16'(dz);
				over_d = 1'b0;
			end
			SRC_X, SRC_Y: begin
				diff_d = 16'(mag);
				over_d = over;
			end
			default: begin
				diff_d = '0;
				over_d = 1'b0;
			end
		endcase
	end

	assign sq = diff_s1 * diff_s1;

	always_ff @(posedge clk) begin
		if (op.ld) begin
			diff_s1 <= diff_d;
			sat_s1  <= over_d;
		end
		case (op.mac)
			MAC_SET: begin
				acc_q <= {1'b0, sq};
				sat_q <= sat_s1;
			end
			MAC_ADD: begin
				acc_q <= acc_q + 33'(sq);
				sat_q <= sat_q | sat_s1;
			end
			default: ;
		endcase
	end

	assign acc = acc_q;
	assign sat = sat_q;

endmodule
`default_nettype wire

// ----- sv/pgd_checker.sv -----
// Port-level checks of the gesture detector, bound to the top level.
`default_nettype none
module pgd_checker import pgd_pkg::*; (
	input wire             clk,
	input wire             arst_n,
	input wire             s_tvalid,
	input wire             s_tready,
	input wire             m_tvalid,
	input wire             m_tready,
	input wire [OUT_W-1:0] m_tdata
);

	// one item in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while previous item still in work");

	// returning to ready always comes with a fresh result in the output slot
	a_result_on_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> m_tvalid)
		else $error("ready returned without a result item");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result item dropped while stalled");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("result item changed while stalled");

endmodule

bind pointer_gesture_detector_core pgd_checker u_pgd_checker (.*);
`default_nettype wire
